>>> src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/tabv_pkg.sv
package tabv_pkg;

  // field_count saturates here
  localparam int FC_W = 10;
  localparam logic [FC_W-1:0] COUNT_CAP = 10'd1023;

  localparam int OUT_BITS = 91;
  localparam int OUT_W    = 96;

  // first member sits in the top bits, so record_ok lands in bit 0
  typedef struct packed {
    logic [8:0]  argument_length;
    logic [6:0]  project_length;
    logic [6:0]  job_length;
    logic [2:0]  command_code;
    logic [31:0] revision;
    logic [31:0] generation;
    logic        record_ok;
  } tabv_res_t;

endpackage

>>> src/tabv_core.sv
module tabv_core #(
  parameter int MAX_RECORD = 1024,
  parameter int ID_MAX     = 64,
  parameter int ARG_MAX    = 511
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,      // consume the byte below this cycle
  input  logic [7:0]          byte_in,
  input  logic                last_in,
  output tabv_pkg::tabv_res_t res
);
  import tabv_pkg::*;

  localparam int RC_W = $clog2(MAX_RECORD + 1);
  localparam int KW_COUNT = 7;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam logic [7:0] HEAD_TEXT [3] = '{8'h52, 8'h44, 8'h31};  // R D 1

  localparam logic [7:0] KW_TEXT [KW_COUNT][9] = '{
    '{"P", "R", "E", "F", "L", "I", "G", "H", "T"},
    '{"S", "T", "A", "R", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"S", "T", "O", "P", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"C", "A", "N", "C", "E", "L", 8'h00, 8'h00, 8'h00},
    '{"P", "U", "B", "L", "I", "S", "H", 8'h00, 8'h00},
    '{"R", "E", "L", "E", "A", "S", "E", 8'h00, 8'h00},
    '{"E", "X", "I", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [FC_W-1:0] KW_LEN [KW_COUNT] = '{
    10'd9, 10'd5, 10'd4, 10'd6, 10'd7, 10'd7, 10'd4
  };

  localparam logic [FC_W-1:0] ID_LIM  = FC_W'(ID_MAX);
  localparam logic [FC_W-1:0] ARG_LIM = FC_W'(ARG_MAX);
  localparam logic [RC_W:0]   REC_LIM = (RC_W+1)'(MAX_RECORD);

  logic [2:0]      field_number_r, field_number_nxt;
  logic [FC_W-1:0] field_count_r,  field_count_nxt;
  logic [RC_W-1:0] record_count_r, record_count_nxt;
  logic [31:0]     number_accum_r, number_accum_nxt;
  logic            fault_r,        fault_nxt;
  logic [6:0]      kw_alive_r,     kw_alive_nxt;
  logic [31:0]     held_gen_r,     held_gen_nxt;
  logic [6:0]      held_job_r,     held_job_nxt;
  logic [6:0]      held_proj_r,    held_proj_nxt;

  logic [RC_W:0]  rec_plus;
  logic           is_digit, is_ident, ok;
  logic [35:0]    times_ten;
  logic [6:0]     kw_hit, kw_len_ok;
  logic           end_ok;
  logic [2:0]     code;

  always_comb begin
    is_digit = (byte_in >= 8'd48) && (byte_in <= 8'd57);
    is_ident = is_digit || ((byte_in >= 8'd65) && (byte_in <= 8'd90)) ||
               ((byte_in >= 8'd97) && (byte_in <= 8'd122)) ||
               (byte_in == CH_UNDER) || (byte_in == CH_DASH);
    // accum * 10 + digit as two shifted adds
    times_ten = {1'b0, number_accum_r, 3'b000} + {3'b000, number_accum_r, 1'b0} +
                {32'd0, byte_in[3:0]};
    for (int k = 0; k < KW_COUNT; k++) begin
      kw_hit[k]    = (field_count_r < KW_LEN[k]) &&
                     (KW_TEXT[k][field_count_r[3:0]] == byte_in);
      kw_len_ok[k] = (KW_LEN[k] == field_count_r);
    end
  end

  always_comb begin
    field_number_nxt = field_number_r;
    field_count_nxt  = field_count_r;
    record_count_nxt = record_count_r;
    number_accum_nxt = number_accum_r;
    fault_nxt        = fault_r;
    kw_alive_nxt     = kw_alive_r;
    held_gen_nxt     = held_gen_r;
    held_job_nxt     = held_job_r;
    held_proj_nxt    = held_proj_r;
    rec_plus         = {1'b0, record_count_r} + 1'b1;
    ok               = 1'b1;

    if (!fault_r) begin
      if (rec_plus >= REC_LIM) begin
        fault_nxt = 1'b1;
      end else begin
        record_count_nxt = rec_plus[RC_W-1:0];
        if ((byte_in == CH_NUL) || (byte_in == CH_CR) || (byte_in == CH_LF)) begin
          fault_nxt = 1'b1;
        end else if (byte_in == CH_TAB) begin
          // close the current field
          case (field_number_r)
            3'd0: begin
              ok = (field_count_r == 10'd3);
            end
            3'd1: begin
              ok = (field_count_r != '0);
              held_job_nxt = field_count_r[6:0];
            end
            3'd2: begin
              ok = (field_count_r != '0);
              held_proj_nxt = field_count_r[6:0];
            end
            3'd3: begin
              ok = (field_count_r != '0);
              held_gen_nxt = number_accum_r;
              number_accum_nxt = '0;
            end
            3'd4: begin
              ok = (field_count_r != '0);
            end
            3'd5: begin
              kw_alive_nxt = kw_alive_r & kw_len_ok;
              ok = |(kw_alive_r & kw_len_ok);
            end
            3'd6: begin
              ok = 1'b0;  // a seventh tab
            end
            default: begin
              ok = 1'b0;
            end
          endcase
          if (ok) begin
            field_number_nxt = field_number_r + 3'd1;
            field_count_nxt  = '0;
          end else begin
            fault_nxt = 1'b1;
          end
        end else begin
          case (field_number_r)
            3'd0: begin
              ok = (field_count_r < 10'd3) && (HEAD_TEXT[field_count_r[1:0]] == byte_in);
            end
            3'd1, 3'd2: begin
              ok = is_ident && (field_count_r < ID_LIM);
            end
            3'd3, 3'd4: begin
              ok = is_digit && (times_ten[35:32] == 4'd0);
              number_accum_nxt = times_ten[31:0];
            end
            3'd5: begin
              kw_alive_nxt = kw_alive_r & kw_hit;
              ok = |(kw_alive_r & kw_hit);
            end
            default: begin
              ok = (field_count_r < ARG_LIM);
            end
          endcase
          if (!ok) begin
            fault_nxt = 1'b1;
          end else if (field_count_r < COUNT_CAP) begin
            field_count_nxt = field_count_r + 1'b1;
          end
        end
      end
    end
  end

  // end-of-record check and result
  always_comb begin
    end_ok = !fault_nxt && (field_number_nxt == 3'd6) && (field_count_nxt <= ARG_LIM);
    code = 3'd0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (kw_alive_nxt[k]) begin
        code = 3'(k);
      end
    end
    res = '0;
    if (end_ok) begin
      res.record_ok       = 1'b1;
      res.generation      = held_gen_nxt;
      res.revision        = number_accum_nxt;
      res.command_code    = code;
      res.job_length      = held_job_nxt;
      res.project_length  = held_proj_nxt;
      res.argument_length = field_count_nxt[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_in)) begin
      field_number_r <= '0;
      field_count_r  <= '0;
      record_count_r <= '0;
      number_accum_r <= '0;
      fault_r        <= 1'b0;
      kw_alive_r     <= '1;
      held_gen_r     <= '0;
      held_job_r     <= '0;
      held_proj_r    <= '0;
    end else if (step) begin
      field_number_r <= field_number_nxt;
      field_count_r  <= field_count_nxt;
      record_count_r <= record_count_nxt;
      number_accum_r <= number_accum_nxt;
      fault_r        <= fault_nxt;
      kw_alive_r     <= kw_alive_nxt;
      held_gen_r     <= held_gen_nxt;
      held_job_r     <= held_job_nxt;
      held_proj_r    <= held_proj_nxt;
    end
  end

endmodule

>>> src/tab_record_validator.sv
// Channel | Dir | Handshake                     | Contents
// in_     | in  | in_tvalid / in_tready         | tdata: byte_value; tlast: last_byte
// out_    | out | out_tvalid / out_tready       | tdata: one result word per record
//
// One byte is taken every cycle unless a last byte waits in the input register.
// The single parse stage after that register sets the rate; the result word is
// registered, with out_tvalid, as a record's last byte passes the parse stage.
// Reset is synchronous (rst_n low) and clears the parser state and both valid
// flags. While a result word waits on out_tready, bytes that are not the last
// of a record keep flowing; only a last byte waits in the input register for
// the output register to free.
module tab_record_validator #(
  parameter int MAX_RECORD = 1024,  // 16 .. 4096
  parameter int ID_MAX     = 64,    // 1 .. 127
  parameter int ARG_MAX    = 511    // 0 .. 511
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,    // [7:0] byte_value
  input  logic                        in_tlast,    // last_byte
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [0] record_ok, [32:1] generation, [64:33] revision, [67:65] command_code,
  // [74:68] job_length, [81:75] project_length, [90:82] argument_length,
  // [95:91] zero
  output logic [tabv_pkg::OUT_W-1:0]  out_tdata
);
  import tabv_pkg::*;

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // output register
  logic       out_valid_r;
  tabv_res_t  out_res_r;

  tabv_res_t  res;
  logic       out_free;
  logic       advance;

  // a byte leaves the input register unless it closes a record and the
  // previous result word is still unclaimed
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && (!in_last_r || out_free);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  tabv_core #(
    .MAX_RECORD (MAX_RECORD),
    .ID_MAX     (ID_MAX),
    .ARG_MAX    (ARG_MAX)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .byte_in (in_byte_r),
    .last_in (in_last_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_W - OUT_BITS)'(0), out_res_r};

endmodule

>>> src/tabv_checker.sv
`include "assert_macros.svh"

module tabv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata
);

  // a stalled result word holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // a rejected record reports nothing but the flag
  `ASSERT_IMPLY(a_reject_zero, clk, rst_n, out_tvalid && !out_tdata[0], out_tdata[95:1] == 95'd0)

  // command code names one of the seven words
  `ASSERT_IMPLY(a_code_range, clk, rst_n, out_tvalid, out_tdata[67:65] != 3'd7)

  // no result word straight out of reset
  `ASSERT_IMPLY(a_reset_quiet, clk, rst_n, !$past(rst_n), !out_tvalid)

endmodule

bind tab_record_validator tabv_checker u_tabv_checker (.*);
